// ===== rtl/adam_optimizer_update_top_defines.svh =====
// Assertion macros shared by the checker.
`ifndef ADAM_OPTIMIZER_UPDATE_TOP_DEFINES_SVH
`define ADAM_OPTIMIZER_UPDATE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ADAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("adam check failed");

// Next-cycle implication checked outside reset.
`define ADAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("adam check failed");

`endif

// ===== rtl/adam_pkg.sv =====
package adam_pkg;

	localparam int unsigned ElementsDef = 4096;
	localparam int unsigned IdxW = 12;
	localparam int unsigned CfgW = 24;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] RegLr = 2'd0;
	localparam logic [CfgIdxW-1:0] RegB1 = 2'd1;
	localparam logic [CfgIdxW-1:0] RegB2 = 2'd2;
	localparam logic [CfgIdxW-1:0] RegEps = 2'd3;

	localparam logic [23:0] LrRst = 24'd16777;
	localparam logic [15:0] B1Rst = 16'd58982;
	localparam logic [15:0] B2Rst = 16'd65470;
	localparam logic [15:0] EpsRst = 16'd1;
	localparam logic [16:0] PowOne = 17'd65536;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POW1,
		ST_POW2,
		ST_SQ_STEP,
		ST_SQ_RUN,
		ST_STEP_MUL,
		ST_STEP_DIV,
		ST_STEP_END,
		ST_RD,
		ST_RD_WAIT,
		ST_M_BLEND,
		ST_G2,
		ST_V_BLEND,
		ST_WRITE,
		ST_VSQ_RUN,
		ST_DEL_MUL,
		ST_DEL_DIV,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [IdxW-1:0] element_index;
		logic signed [31:0] gradient;
		logic signed [31:0] param_value;
		logic new_pass;
	} in_word_t;

	typedef struct packed {
		logic [IdxW-1:0] result_index;
		logic signed [31:0] updated_param;
		logic saturated;
	} out_word_t;

endpackage

// ===== rtl/adam_if.sv =====
interface adam_if #(
	parameter type word_t = logic
);
	logic valid;
	logic ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/adam_optimizer_update_top.sv =====
// Adam optimiser update, one element per input word, Q16.16 fixed point.
// Each in-range word runs a 32-step root and a 64-step divide on one shared
// shift-subtract unit; a word with new_pass first runs a further root and divide.
// Throughput: one word at a time; the next word is taken in the cycle after the result leaves.
// Reset (arst_n low, asynchronous): control and config registers to defaults, then a
// clearing pass over every entry zeroes the momentum and velocity stores before any word.
module adam_optimizer_update_top
	import adam_pkg::*;
#(
	parameter int unsigned ELEMENTS = ElementsDef
) (
	input  logic clk,
	input  logic arst_n,
	adam_if.sink in_ch,
	adam_if.source out_ch,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_data
);

	localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

	// Configuration registers.
	logic [23:0] lr_q;
	logic [15:0] b1_q, b2_q, eps_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LrRst;
			b1_q <= B1Rst;
			b2_q <= B2Rst;
			eps_q <= EpsRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLr:  lr_q <= cfg_data;
				RegB1:  b1_q <= cfg_data[15:0];
				RegB2:  b2_q <= cfg_data[15:0];
				RegEps: eps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Element stores, read and written in clocked blocks.
	logic signed [31:0] m_mem [ELEMENTS];
	logic [63:0] v_mem [ELEMENTS];
	logic signed [31:0] m_rd_q;
	logic [63:0] v_rd_q;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic signed [31:0] mem_wm;
	logic [63:0] mem_wv;
	always_ff @(posedge clk) begin
		if (mem_we) begin
			m_mem[mem_addr] <= mem_wm;
			v_mem[mem_addr] <= mem_wv;
		end
		m_rd_q <= m_mem[mem_addr];
		v_rd_q <= v_mem[mem_addr];
	end

	state_t state_q, state_d;
	in_word_t in_q;
	out_word_t out_q;
	logic [AW:0] clr_q;
	logic [16:0] b1p_q, b2p_q;
	logic [31:0] step_q;
	logic signed [31:0] m_q;
	logic [63:0] v_q;
	logic in_range;

	// Shared shift-subtract unit: root (2 operand bits per step) or divide (1 bit).
	// acc_q holds the remainder, r_q the root or quotient, x_q the operand.
	logic [65:0] acc_q;
	logic [63:0] r_q, x_q, den_q;
	logic [6:0] cnt_q;

	// Blend: cur + floor((tgt - cur) * k / 65536), computed exactly.
	function automatic logic signed [65:0] blend_f(
		input logic signed [65:0] cur,
		input logic signed [65:0] tgt,
		input logic [16:0] k
	);
		logic signed [65:0] d;
		logic signed [84:0] p;
		d = tgt - cur;
		p = d * $signed({1'b0, k});
		blend_f = cur + 66'(p >>> 16);
	endfunction

	assign in_range = ({20'd0, in_q.element_index} < 32'(ELEMENTS));
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data = out_q;
	assign mem_addr = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : AW'(in_q.element_index);

	logic [65:0] sq_trial;
	logic [64:0] dv_trial;
	assign sq_trial = {acc_q[63:0], x_q[63:62]} - {r_q, 2'b01};
	assign dv_trial = {acc_q[63:0], x_q[63]} - {1'b0, den_q};

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_wm = m_q;
		mem_wv = v_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wm = '0;
				mem_wv = '0;
				if (clr_q == (AW+1)'(ELEMENTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: if (in_ch.valid) state_d = ST_RD;
			ST_RD: state_d = in_q.new_pass ? ST_POW1 : ST_RD_WAIT;
			ST_POW1: state_d = ST_POW2;
			ST_POW2: state_d = ST_SQ_STEP;
			ST_SQ_STEP: state_d = ST_SQ_RUN;
			ST_SQ_RUN: if (cnt_q == 7'd31) state_d = ST_STEP_MUL;
			ST_STEP_MUL: state_d = ST_STEP_DIV;
			ST_STEP_DIV: if (cnt_q == 7'd63) state_d = ST_STEP_END;
			ST_STEP_END: state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = in_range ? ST_M_BLEND : ST_DONE;
			ST_M_BLEND: state_d = ST_G2;
			ST_G2: state_d = ST_V_BLEND;
			ST_V_BLEND: state_d = ST_WRITE;
			ST_WRITE: begin
				mem_we = 1'b1;
				state_d = ST_VSQ_RUN;
			end
			ST_VSQ_RUN: if (cnt_q == 7'd31) state_d = ST_DEL_MUL;
			ST_DEL_MUL: state_d = ST_DEL_DIV;
			ST_DEL_DIV: if (cnt_q == 7'd63) state_d = ST_DONE;
			ST_DONE: state_d = ST_OUT;
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			b1p_q <= PowOne;
			b2p_q <= PowOne;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_POW1) begin
				b1p_q <= 17'(({17'd0, b1p_q} * {18'd0, b1_q}) >> 16);
				b2p_q <= 17'(({17'd0, b2p_q} * {18'd0, b2_q}) >> 16);
			end
			if (state_q == ST_STEP_END) begin
				if (den_q == '0) step_q <= '0;
				else if (r_q[63:32] != '0) step_q <= '1;
				else step_q <= r_q[31:0];
			end
		end
	end

	// Datapath: payload registers, no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: in_q <= in_ch.data;
			ST_POW2: begin
				// Load root operand (1 - b2^t) << 32.
				x_q <= {15'd0, PowOne - b2p_q, 32'd0};
				acc_q <= '0;
				r_q <= '0;
				cnt_q <= '0;
			end
			ST_SQ_RUN, ST_VSQ_RUN: begin
				// One bit of the root per step, from two operand bits.
				if (!sq_trial[65]) begin
					acc_q <= sq_trial;
					r_q <= {r_q[62:0], 1'b1};
				end else begin
					acc_q <= {acc_q[63:0], x_q[63:62]};
					r_q <= {r_q[62:0], 1'b0};
				end
				x_q <= {x_q[61:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_STEP_MUL: begin
				// The root of a value below 2^49 fits in 25 bits.
				x_q <= {40'd0, lr_q} * {39'd0, r_q[24:0]};
				den_q <= {39'd0, PowOne - b1p_q, 8'd0};
			end
			ST_DEL_MUL: begin
				x_q <= {32'd0, step_q} * {32'd0, (m_q < 0) ? 32'(-m_q) : 32'(m_q)};
				den_q <= (r_q + {48'd0, eps_q}) << 8;
			end
			ST_STEP_DIV, ST_DEL_DIV: begin
				// One quotient bit per step.
				if (!dv_trial[64]) begin
					acc_q <= {2'b0, dv_trial[63:0]};
					r_q <= {r_q[62:0], 1'b1};
				end else begin
					acc_q <= {acc_q[64:0], x_q[63]};
					r_q <= {r_q[62:0], 1'b0};
				end
				x_q <= {x_q[62:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_M_BLEND: m_q <= 32'(blend_f(66'(m_rd_q), 66'(in_q.gradient),
				17'(PowOne - {1'b0, b1_q})));
			ST_G2: x_q <= 64'(in_q.gradient * in_q.gradient);
			ST_V_BLEND: begin
				v_q <= 64'(blend_f($signed({2'b0, v_rd_q}), $signed({2'b0, x_q}),
					17'(PowOne - {1'b0, b2_q})));
			end
			ST_WRITE: begin
				x_q <= v_q;
				acc_q <= '0;
				r_q <= '0;
				cnt_q <= '0;
			end
			ST_DONE: begin
				out_q.result_index <= in_q.element_index;
				out_q.updated_param <= in_q.param_value;
				out_q.saturated <= 1'b0;
				if (in_range && den_q != '0) begin
					if (m_q < 0) begin
						if ($signed({{33{in_q.param_value[31]}}, in_q.param_value})
							+ $signed({1'b0, r_q}) > 97'sd2147483647
							|| r_q[63:32] != '0) begin
							out_q.updated_param <= 32'h7fffffff;
							out_q.saturated <= 1'b1;
						end else
							out_q.updated_param <= in_q.param_value + r_q[31:0];
					end else begin
						if ($signed({{33{in_q.param_value[31]}}, in_q.param_value})
							- $signed({1'b0, r_q}) < -97'sd2147483648
							|| r_q[63:32] != '0) begin
							out_q.updated_param <= 32'h80000000;
							out_q.saturated <= 1'b1;
						end else
							out_q.updated_param <= in_q.param_value - r_q[31:0];
					end
				end
			end
			default: ;
		endcase
		// Clear the remainder and quotient after each multiply that feeds a divide.
		if (state_q == ST_STEP_MUL || state_q == ST_DEL_MUL) begin
			acc_q <= '0;
			r_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == ST_SQ_STEP) cnt_q <= '0;
	end

endmodule

// ===== rtl/adam_chk.sv =====
`include "adam_optimizer_update_top_defines.svh"
module adam_chk
	import adam_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [IdxW-1:0] out_idx
);
	`ADAM_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`ADAM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_idx))
	`ADAM_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind adam_optimizer_update_top adam_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_idx(out_ch.data.result_index)
);
